// File: hdl/bufp_pkg.sv
// shared types and constants for the buffered serial port ring pair
`timescale 1ns / 1ps
package bufp_pkg;

  // field widths of one item on either side
  localparam int KIND_W     = 2;
  localparam int DATA_W     = 9;
  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int LEVEL_W    = 9;
  localparam int IN_TDATA_W = 16;
  localparam int IN_TUSER_W = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 4;
  localparam int OUT_PAD_W  = OUT_TDATA_W - BYTE_W - 1 - 2 * LEVEL_W;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // event kinds
  typedef enum logic [KIND_W-1:0] {
    OP_LINE_RX  = 2'd0,
    OP_TX_READY = 2'd1,
    OP_SW_SEND  = 2'd2,
    OP_SW_READ  = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_RX_FULL  = 3'd1,
    ST_TX_FULL  = 3'd2,
    ST_RD_EMPTY = 3'd3,
    ST_TX_IDLE  = 3'd4
  } status_e;

  // classified command handed from front to back
  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] data;
  } cmd_t;

endpackage

// File: hdl/bufp_front.sv
// front stage: accepts input items, classifies them and holds them for the queue
`timescale 1ns / 1ps
module bufp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bufp_pkg::IN_TUSER_W-1:0] in_kind_i,
  input  logic [bufp_pkg::DATA_W-1:0]   in_data_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output bufp_pkg::cmd_t                cmd_o
);

  logic           vld_q, vld_d;
  bufp_pkg::cmd_t cmd_q, cmd_d;
  logic           accept;

  // input register frees up as soon as the queue takes its item
  assign in_ready_o  = !vld_q || cmd_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  // classify: decode the kind, keep only the stored byte
  always_comb begin
    vld_d = vld_q;
    cmd_d = cmd_q;
    if (accept) begin
      vld_d      = 1'b1;
      cmd_d.op   = bufp_pkg::op_e'(in_kind_i);
      cmd_d.data = in_data_i[bufp_pkg::BYTE_W-1:0];
    end else if (cmd_ready_i) begin
      vld_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

endmodule

// File: hdl/bufp_queue.sv
// short command queue between the front and back stages
`timescale 1ns / 1ps
module bufp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  bufp_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output bufp_pkg::cmd_t pop_cmd_o
);

  bufp_pkg::cmd_t                     slot_q [bufp_pkg::QUEUE_DEPTH];
  logic [bufp_pkg::QUEUE_IDX_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [bufp_pkg::QUEUE_CNT_W-1:0]   cnt_q, cnt_d;
  logic                               do_push, do_pop;

  assign push_ready_o = cnt_q != bufp_pkg::QUEUE_CNT_W'(bufp_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = slot_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == bufp_pkg::QUEUE_IDX_W'(bufp_pkg::QUEUE_DEPTH - 1)) ?
             '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == bufp_pkg::QUEUE_IDX_W'(bufp_pkg::QUEUE_DEPTH - 1)) ?
             '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// File: hdl/bufp_ring.sv
// one byte ring: storage, wrap pointers, level and registered read port
`timescale 1ns / 1ps
module bufp_ring #(
  parameter int DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         pop_i,
  input  logic [bufp_pkg::BYTE_W-1:0]  wdata_i,
  output logic [bufp_pkg::BYTE_W-1:0]  rdata_o,
  output logic                         full_o,
  output logic                         empty_o,
  output logic [bufp_pkg::LEVEL_W-1:0] level_o
);

  localparam int PW = $clog2(2 * DEPTH);
  localparam int IW = $clog2(DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(2 * DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P  = PW'(DEPTH);
  localparam logic [PW:0]   SPAN     = (PW + 1)'(2 * DEPTH);

  logic [bufp_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [bufp_pkg::BYTE_W-1:0] rdata_q;
  logic [PW-1:0]               wptr_q, wptr_d, rptr_q, rptr_d;
  logic [IW-1:0]               widx, ridx;
  logic [PW:0]                 lvl_wide;
  logic [PW-1:0]               lvl;

  // entry index is the pointer folded into one lap
  assign widx = (wptr_q >= DEPTH_P) ? IW'(wptr_q - DEPTH_P) : IW'(wptr_q);
  assign ridx = (rptr_q >= DEPTH_P) ? IW'(rptr_q - DEPTH_P) : IW'(rptr_q);

  // level over pointers that count two laps
  assign lvl_wide = (wptr_q >= rptr_q) ?
                    ({1'b0, wptr_q} - {1'b0, rptr_q}) :
                    ({1'b0, wptr_q} + SPAN - {1'b0, rptr_q});
  assign lvl      = PW'(lvl_wide);
  assign full_o   = lvl == DEPTH_P;
  assign empty_o  = lvl == '0;
  assign level_o  = bufp_pkg::LEVEL_W'(lvl);
  assign rdata_o  = rdata_q;

  // pointer advance with wrap after two laps
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  // storage, read data held until the next pop
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[widx] <= wdata_i;
    end
    if (pop_i) begin
      rdata_q <= mem[ridx];
    end
  end

endmodule

// File: hdl/bufp_back.sv
// back stage: carries out ring events and registers the result item
`timescale 1ns / 1ps
module bufp_back #(
  parameter int RX_DEPTH = 256,
  parameter int TX_DEPTH = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  bufp_pkg::cmd_t                     cmd_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output logic [bufp_pkg::OUT_TDATA_W-1:0]   res_data_o,
  output logic [bufp_pkg::OUT_TUSER_W-1:0]   res_user_o
);

  typedef enum logic {
    B_EXEC,
    B_DONE
  } state_e;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_RX,
    SRC_TX
  } src_e;

  state_e                          state_q, state_d;
  src_e                            src_q, src_d;
  bufp_pkg::status_e               status_q, status_d;
  logic                            line_q, line_d;
  logic                            tx_active_q, tx_active_d;
  logic                            res_valid_q, res_valid_d;
  logic [bufp_pkg::OUT_TDATA_W-1:0] res_data_q, res_data_d;
  logic [bufp_pkg::OUT_TUSER_W-1:0] res_user_q, res_user_d;

  logic                            rx_push, rx_pop, tx_push, tx_pop;
  logic                            rx_full, rx_empty, tx_full, tx_empty;
  logic [bufp_pkg::BYTE_W-1:0]     rx_rdata, tx_rdata, out_byte;
  logic [bufp_pkg::LEVEL_W-1:0]    rx_level, tx_level;
  logic                            take, load;

  // receive ring
  bufp_ring #(
    .DEPTH (RX_DEPTH)
  ) u_rx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rx_push),
    .pop_i   (rx_pop),
    .wdata_i (cmd_i.data),
    .rdata_o (rx_rdata),
    .full_o  (rx_full),
    .empty_o (rx_empty),
    .level_o (rx_level)
  );

  // transmit ring
  bufp_ring #(
    .DEPTH (TX_DEPTH)
  ) u_tx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tx_push),
    .pop_i   (tx_pop),
    .wdata_i (cmd_i.data),
    .rdata_o (tx_rdata),
    .full_o  (tx_full),
    .empty_o (tx_empty),
    .level_o (tx_level)
  );

  assign cmd_ready_o = state_q == B_EXEC;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign load        = (state_q == B_DONE) && (!res_valid_q || res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_data_q;
  assign res_user_o  = res_user_q;

  // event decode against ring occupancy
  always_comb begin
    rx_push     = 1'b0;
    rx_pop      = 1'b0;
    tx_push     = 1'b0;
    tx_pop      = 1'b0;
    status_d    = status_q;
    line_d      = line_q;
    src_d       = src_q;
    tx_active_d = tx_active_q;
    if (take) begin
      status_d = bufp_pkg::ST_OK;
      line_d   = 1'b0;
      src_d    = SRC_NONE;
      unique case (cmd_i.op)
        bufp_pkg::OP_LINE_RX: begin
          if (rx_full) begin
            status_d = bufp_pkg::ST_RX_FULL;
          end else begin
            rx_push = 1'b1;
          end
        end
        bufp_pkg::OP_TX_READY: begin
          if (tx_empty) begin
            status_d    = bufp_pkg::ST_TX_IDLE;
            tx_active_d = 1'b0;
          end else begin
            tx_pop      = 1'b1;
            line_d      = 1'b1;
            src_d       = SRC_TX;
            tx_active_d = 1'b1;
          end
        end
        bufp_pkg::OP_SW_SEND: begin
          if (tx_full) begin
            status_d = bufp_pkg::ST_TX_FULL;
          end else begin
            tx_push     = 1'b1;
            tx_active_d = 1'b1;
          end
        end
        bufp_pkg::OP_SW_READ: begin
          if (rx_empty) begin
            status_d = bufp_pkg::ST_RD_EMPTY;
          end else begin
            rx_pop = 1'b1;
            src_d  = SRC_RX;
          end
        end
        default: begin
          status_d = bufp_pkg::ST_OK;
        end
      endcase
    end
  end

  // returned byte from whichever ring was popped
  always_comb begin
    case (src_q)
      SRC_RX:  out_byte = rx_rdata;
      SRC_TX:  out_byte = tx_rdata;
      default: out_byte = '0;
    endcase
  end

  // result assembly and output register
  always_comb begin
    res_valid_d = res_valid_q;
    res_data_d  = res_data_q;
    res_user_d  = res_user_q;
    if (load) begin
      res_valid_d = 1'b1;
      res_data_d  = {bufp_pkg::OUT_PAD_W'(0), tx_level, rx_level, tx_active_q, out_byte};
      res_user_d  = {line_q, status_q};
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  // sequencer: execute, then hand the result to the output register
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_EXEC: begin
        if (take) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (load) begin
          state_d = B_EXEC;
        end
      end
      default: begin
        state_d = B_EXEC;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_EXEC;
      tx_active_q <= 1'b0;
      res_valid_q <= 1'b0;
      src_q       <= SRC_NONE;
      status_q    <= bufp_pkg::ST_OK;
      line_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      tx_active_q <= tx_active_d;
      res_valid_q <= res_valid_d;
      src_q       <= src_d;
      status_q    <= status_d;
      line_q      <= line_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_data_q <= res_data_d;
    res_user_q <= res_user_d;
  end

endmodule

// File: hdl/buffered_uart_fifo_pair_unit.sv
// Buffered serial port ring pair: receive and transmit byte rings driven by
// one event per input item, each answered by exactly one result item. An
// input item is registered and classified by the front stage, waits in a
// two-entry queue, and is carried out by the back stage, whose two-state
// sequencer updates the ring and starts the registered storage read in its
// execute state and loads the output register in its done state, taking no
// new item until that load, which waits while the output side holds back an
// earlier result. The result is held in the output register until the output
// side is ready. A full receive ring drops the byte, a full transmit ring
// rejects the send, a read on an empty ring and a transmitter ready on an
// empty ring return a status instead of a byte. Ring levels are reported
// modulo 512. Reset empties both rings; ring storage is not cleared.
`timescale 1ns / 1ps
module buffered_uart_fifo_pair_unit #(
  parameter int RX_DEPTH = 256,
  parameter int TX_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [8:0] data, [15:9] zero
  input  logic [15:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [8] tx_active, [17:9] rx_level, [26:18] tx_level,
  // [31:27] zero
  output logic [31:0] m_axis_tdata,
  // [2:0] status, [3] line_byte_valid
  output logic [3:0]  m_axis_tuser
);

  logic           f_valid, f_ready, b_valid, b_ready;
  bufp_pkg::cmd_t f_cmd, b_cmd;

  // accept and classify
  bufp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata[bufp_pkg::DATA_W-1:0]),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  // decoupling queue
  bufp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_cmd_o    (b_cmd)
  );

  // ring execution and result register
  bufp_back #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata),
    .res_user_o  (m_axis_tuser)
  );

endmodule
